### hdl/bftc_pkg.sv
// Shared types, register map, codes and defaults for the text console renderer.
`timescale 1ns / 1ps
`default_nettype none

package bftc_pkg;

    localparam int GLYPH_STORE_DEPTH_DEF = 4096;
    localparam int MAX_GLYPH_ROWS_DEF    = 16;
    localparam int ADDRESS_BITS_DEF      = 18;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 32;

    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd2;
    localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_FG_COLOR      = 3'd4;
    localparam logic [2:0] REG_BG_COLOR      = 3'd5;
    localparam logic [2:0] REG_SEE_THROUGH   = 3'd6;

    localparam logic [9:0]  RST_SCREEN_WIDTH  = 10'd220;
    localparam logic [9:0]  RST_SCREEN_HEIGHT = 10'd176;
    localparam logic [3:0]  RST_GLYPH_WIDTH   = 4'd6;
    localparam logic [4:0]  RST_GLYPH_HEIGHT  = 5'd10;
    localparam logic [15:0] RST_FG_COLOR      = 16'hFFFF;
    localparam logic [15:0] RST_BG_COLOR      = 16'h0018;
    localparam logic        RST_SEE_THROUGH   = 1'b0;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PRINT = 1'b1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    localparam logic [1:0] RES_ROW    = 2'd0;
    localparam logic [1:0] RES_CLEAR  = 2'd1;
    localparam logic [1:0] RES_UPDATE = 2'd2;

    typedef struct packed {
        logic [9:0]  screen_width;
        logic [9:0]  screen_height;
        logic [3:0]  glyph_width;
        logic [4:0]  glyph_height;
        logic [15:0] foreground_color;
        logic [15:0] background_color;
        logic        see_through;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/bitmap_font_text_console.sv
// Top level of the bitmap font text console renderer.
//
// Channel  Direction  Handshake           Contents
// s_*      in         s_tvalid/s_tready   glyph byte load or character to print
// m_*      out        m_tvalid/m_tready   glyph row write, clear or display update
// APB      in         psel/penable/pready configuration registers at 4*index
//
// A glyph load is written to the glyph RAM as it is accepted. A printable character passes
// through S_PREP1 and S_PREP2 for the cursor products, S_ROW for each glyph row read from
// the glyph RAM, and S_ADV for the cursor step. Newline passes through S_NL and S_UPD;
// carriage return only resets the column. Output stalls hold the sequencer on the current row.
// Reset clears the cursor and returns the configuration registers to their defaults; the glyph RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_font_text_console
    import bftc_pkg::*;
#(
    parameter int GLYPH_STORE_DEPTH = GLYPH_STORE_DEPTH_DEF,
    parameter int MAX_GLYPH_ROWS    = MAX_GLYPH_ROWS_DEF,
    parameter int ADDRESS_BITS      = ADDRESS_BITS_DEF,
    localparam int ODW = ((ADDRESS_BITS + 45 + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // char_code[7:0], glyph_index[19:8], glyph_byte[27:20], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // kind[0]
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // row_address, pixel_mask, row_pixels, fg_value, bg_value,
    // write_clear_pixels, zero pad
    output logic      [ODW-1:0]        m_tdata,
    // result_kind[1:0]
    output logic      [1:0]            m_tuser,
    output logic                       m_tlast
);

    localparam int RAW = $clog2(GLYPH_STORE_DEPTH);

    cfg_t           cfg;
    logic           ram_we;
    logic [RAW-1:0] ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [RAW-1:0] ram_raddr;
    logic [7:0]     ram_rdata;

    bftc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bftc_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_STORE_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bftc_engine #(
        .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH),
        .MAX_GLYPH_ROWS    (MAX_GLYPH_ROWS),
        .ADDRESS_BITS      (ADDRESS_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### hdl/bftc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module bftc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/bftc_regs.sv
// APB configuration register file for the text console renderer.
`timescale 1ns / 1ps
`default_nettype none

module bftc_regs
    import bftc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_SCREEN_WIDTH:  cfg_next.screen_width     = pwdata[9:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height    = pwdata[9:0];
                REG_GLYPH_WIDTH:   cfg_next.glyph_width      = pwdata[3:0];
                REG_GLYPH_HEIGHT:  cfg_next.glyph_height     = pwdata[4:0];
                REG_FG_COLOR:      cfg_next.foreground_color = pwdata[15:0];
                REG_BG_COLOR:      cfg_next.background_color = pwdata[15:0];
                REG_SEE_THROUGH:   cfg_next.see_through      = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(cfg_reg.screen_height);
            REG_GLYPH_WIDTH:   prdata = CFG_DATA_W'(cfg_reg.glyph_width);
            REG_GLYPH_HEIGHT:  prdata = CFG_DATA_W'(cfg_reg.glyph_height);
            REG_FG_COLOR:      prdata = CFG_DATA_W'(cfg_reg.foreground_color);
            REG_BG_COLOR:      prdata = CFG_DATA_W'(cfg_reg.background_color);
            REG_SEE_THROUGH:   prdata = CFG_DATA_W'(cfg_reg.see_through);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width     <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height    <= RST_SCREEN_HEIGHT;
            cfg_reg.glyph_width      <= RST_GLYPH_WIDTH;
            cfg_reg.glyph_height     <= RST_GLYPH_HEIGHT;
            cfg_reg.foreground_color <= RST_FG_COLOR;
            cfg_reg.background_color <= RST_BG_COLOR;
            cfg_reg.see_through      <= RST_SEE_THROUGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hdl/bftc_engine.sv
// Command sequencer, cursor, address generation and output register.
`timescale 1ns / 1ps
`default_nettype none

module bftc_engine
    import bftc_pkg::*;
#(
    parameter int GLYPH_STORE_DEPTH = GLYPH_STORE_DEPTH_DEF,
    parameter int MAX_GLYPH_ROWS    = MAX_GLYPH_ROWS_DEF,
    parameter int ADDRESS_BITS      = ADDRESS_BITS_DEF,
    localparam int RAW  = $clog2(GLYPH_STORE_DEPTH),
    localparam int ODW  = ((ADDRESS_BITS + 45 + 7) / 8) * 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [ODW-1:0]       m_tdata,
    output logic      [1:0]           m_tuser,
    output logic                      m_tlast,
    output logic                      ram_we,
    output logic      [RAW-1:0]       ram_waddr,
    output logic      [7:0]           ram_wdata,
    output logic                      ram_re,
    output logic      [RAW-1:0]       ram_raddr,
    input  wire logic [7:0]           ram_rdata
);

    localparam int GHW = $clog2(MAX_GLYPH_ROWS + 1);
    localparam int YW  = 9 + GHW;
    localparam int GAW = 8 + GHW;
    localparam int NW  = 10 + GHW;
    localparam int PW  = YW + 11;
    localparam int BW  = (PW > ADDRESS_BITS) ? PW : ADDRESS_BITS;
    localparam int PADW = ODW - ADDRESS_BITS - 45;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NL    = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_PREP1 = 3'd3;
    localparam logic [2:0] S_PREP2 = 3'd4;
    localparam logic [2:0] S_ROW   = 3'd5;
    localparam logic [2:0] S_ADV   = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [8:0]              col_reg, col_next;
    logic [8:0]              row_reg, row_next;
    logic [7:0]              code_reg, code_next;
    logic [11:0]             x_reg, x_next;
    logic [YW-1:0]           y_reg, y_next;
    logic [GAW-1:0]          gaddr_reg, gaddr_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic [GHW-1:0]          rcnt_reg, rcnt_next;
    logic [ADDRESS_BITS-1:0] raddr_reg, raddr_next;

    logic                    ovalid_reg, ovalid_next;
    logic [1:0]              okind_reg, okind_next;
    logic [ADDRESS_BITS-1:0] oaddr_reg, oaddr_next;
    logic [7:0]              omask_reg, omask_next;
    logic [3:0]              opix_reg, opix_next;
    logic [15:0]             ofg_reg, ofg_next;
    logic [15:0]             obg_reg, obg_next;
    logic                    owclr_reg, owclr_next;
    logic                    olast_reg, olast_next;

    logic [7:0]     in_code;
    logic [11:0]    in_index;
    logic [7:0]     in_byte;
    logic           accept;
    logic           out_free;
    logic [3:0]     gw_eff;
    logic [GHW-1:0] gh_eff;
    logic [7:0]     keep;
    logic [8:0]     row_inc;
    logic [8:0]     col_inc;
    logic [NW-1:0]  nl_prod;
    logic [13:0]    col_prod;
    logic [BW-1:0]  base_full;
    logic [GAW-1:0] gaddr_inc;
    logic           row_last;

    assign in_code  = s_tdata[7:0];
    assign in_index = s_tdata[19:8];
    assign in_byte  = s_tdata[27:20];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;

    assign gw_eff = (cfg.glyph_width == 4'd0) ? 4'd1 :
                    (cfg.glyph_width > 4'd8)  ? 4'd8 : cfg.glyph_width;
    assign gh_eff = (cfg.glyph_height == 5'd0) ? GHW'(1) :
                    (32'(cfg.glyph_height) > 32'(MAX_GLYPH_ROWS)) ? GHW'(MAX_GLYPH_ROWS) :
                    GHW'(cfg.glyph_height);
    assign keep   = ~(8'hFF >> gw_eff);

    assign row_inc  = row_reg + 9'd1;
    assign col_inc  = col_reg + 9'd1;
    assign nl_prod  = (NW'(row_inc) + NW'(1)) * NW'(gh_eff);
    assign col_prod = (14'(col_inc) + 14'd1) * 14'(gw_eff);
    assign base_full = BW'(y_reg) * BW'(cfg.screen_width) + BW'(x_reg);
    assign gaddr_inc = gaddr_reg + GAW'(1);
    assign row_last  = (rcnt_reg == (gh_eff - GHW'(1)));

    assign ram_we    = accept && (s_tuser == KIND_LOAD)
                       && (32'(in_index) < 32'(GLYPH_STORE_DEPTH));
    assign ram_waddr = RAW'(in_index);
    assign ram_wdata = in_byte;

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        code_next   = code_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        gaddr_next  = gaddr_reg;
        rd_ok_next  = rd_ok_reg;
        rcnt_next   = rcnt_reg;
        raddr_next  = raddr_reg;
        ram_re      = 1'b0;
        ram_raddr   = RAW'(gaddr_reg);

        ovalid_next = ovalid_reg && !m_tready;
        okind_next  = okind_reg;
        oaddr_next  = oaddr_reg;
        omask_next  = omask_reg;
        opix_next   = opix_reg;
        ofg_next    = ofg_reg;
        obg_next    = obg_reg;
        owclr_next  = owclr_reg;
        olast_next  = olast_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (s_tuser == KIND_PRINT))
                begin
                    if (in_code == CH_NEWLINE)
                    begin
                        col_next   = '0;
                        state_next = S_NL;
                    end
                    else if (in_code == CH_RETURN)
                    begin
                        col_next = '0;
                    end
                    else
                    begin
                        code_next  = in_code;
                        state_next = S_PREP1;
                    end
                end
            end
            S_NL:
            begin
                if (out_free)
                begin
                    if (nl_prod > NW'(cfg.screen_height))
                    begin
                        row_next    = '0;
                        ovalid_next = 1'b1;
                        okind_next  = RES_CLEAR;
                        oaddr_next  = '0;
                        omask_next  = '0;
                        opix_next   = gw_eff;
                        ofg_next    = cfg.foreground_color;
                        obg_next    = cfg.background_color;
                        owclr_next  = 1'b1;
                        olast_next  = 1'b0;
                    end
                    else
                    begin
                        row_next = row_inc;
                    end
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = RES_UPDATE;
                    oaddr_next  = '0;
                    omask_next  = '0;
                    opix_next   = gw_eff;
                    ofg_next    = cfg.foreground_color;
                    obg_next    = cfg.background_color;
                    owclr_next  = 1'b0;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_PREP1:
            begin
                x_next     = 12'(col_reg) * 12'(gw_eff);
                y_next     = YW'(row_reg) * YW'(gh_eff);
                gaddr_next = GAW'(code_reg) * GAW'(gh_eff);
                state_next = S_PREP2;
            end
            S_PREP2:
            begin
                raddr_next = base_full[ADDRESS_BITS-1:0];
                ram_re     = 1'b1;
                ram_raddr  = RAW'(gaddr_reg);
                rd_ok_next = (32'(gaddr_reg) < 32'(GLYPH_STORE_DEPTH));
                rcnt_next  = '0;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = RES_ROW;
                    oaddr_next  = raddr_reg;
                    omask_next  = rd_ok_reg ? (ram_rdata & keep) : 8'd0;
                    opix_next   = gw_eff;
                    ofg_next    = cfg.foreground_color;
                    obg_next    = cfg.background_color;
                    owclr_next  = !cfg.see_through;
                    olast_next  = row_last;
                    if (row_last)
                    begin
                        state_next = S_ADV;
                    end
                    else
                    begin
                        gaddr_next = gaddr_inc;
                        ram_re     = 1'b1;
                        ram_raddr  = RAW'(gaddr_inc);
                        rd_ok_next = (32'(gaddr_inc) < 32'(GLYPH_STORE_DEPTH));
                        raddr_next = raddr_reg + ADDRESS_BITS'(cfg.screen_width);
                        rcnt_next  = rcnt_reg + GHW'(1);
                    end
                end
            end
            S_ADV:
            begin
                if (col_prod > 14'(cfg.screen_width))
                begin
                    col_next = '0;
                    row_next = row_inc;
                end
                else
                begin
                    col_next = col_inc;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        gaddr_reg <= gaddr_next;
        rd_ok_reg <= rd_ok_next;
        rcnt_reg  <= rcnt_next;
        raddr_reg <= raddr_next;
        okind_reg <= okind_next;
        oaddr_reg <= oaddr_next;
        omask_reg <= omask_next;
        opix_reg  <= opix_next;
        ofg_reg   <= ofg_next;
        obg_reg   <= obg_next;
        owclr_reg <= owclr_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {{PADW{1'b0}}, owclr_reg, obg_reg, ofg_reg, opix_reg, omask_reg,
                       oaddr_reg};

endmodule

`default_nettype wire
